@@ sv/double_hash_string_table_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the double hash string table checker
// Each macro expands to one labeled concurrent assertion on clk_i; DHST_ASSERT is also disabled by rst_ni.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_STRING_TABLE_ASSERT_SVH
`define DOUBLE_HASH_STRING_TABLE_ASSERT_SVH

// Assertion that is switched off while reset is held.
`define DHST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion that also holds while reset is held.
`define DHST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/dhst_pkg.sv @@
// ----------------------------------------------------------------------------
// dhst_pkg
// Field widths and codes shared by the double hash string table files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dhst_pkg;

  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 7;
  localparam int KEY_W    = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;
  localparam int SUM_W    = 13;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FOUND     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

endpackage

`default_nettype wire

@@ sv/dhst_cfg_if.sv @@
// ----------------------------------------------------------------------------
// dhst_cfg_if
// Write channel for the table_size register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dhst_cfg_if
  import dhst_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] table_size;

  modport source (output valid, output table_size, input ready);
  modport sink   (input valid, input table_size, output ready);
endinterface

`default_nettype wire

@@ sv/dhst_req_if.sv @@
// ----------------------------------------------------------------------------
// dhst_req_if
// Request channel: clear, insert character or query slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dhst_req_if
  import dhst_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;
  logic [KEY_W-1:0]  query_key;

  modport source (output valid, output command, output char_code, output last_char,
                  output query_key, input ready);
  modport sink   (input valid, input command, input char_code, input last_char,
                  input query_key, output ready);
endinterface

`default_nettype wire

@@ sv/dhst_rsp_if.sv @@
// ----------------------------------------------------------------------------
// dhst_rsp_if
// Result channel: insert status or query characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dhst_rsp_if
  import dhst_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    slot;
  logic [CHAR_W-1:0]   char_out;
  logic                final_result;

  modport source (output valid, output status, output slot, output char_out,
                  output final_result, input ready);
  modport sink   (input valid, input status, input slot, input char_out,
                  input final_result, output ready);
endinterface

`default_nettype wire

@@ sv/double_hash_string_table.sv @@
// ----------------------------------------------------------------------------
// double_hash_string_table
// Open-addressed string table with double hashing over the character sum.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i  writes table_size (slots in use); it is always ready.
//   req_i  carries requests: clear, insert character, query slot.
//   rsp_o  carries results; final_result marks the last one of a request.
// Sequence:
//   A clear or a non-final insert character completes without leaving idle.
//   A final character runs two bit-serial remainders on the shared modulo
//   unit, probes slots one at a time, then copies each stored character
//   of the pending string into its slot and hands the status to the
//   output register.
//   A query checks the slot, then reads each character from the string
//   memory.
//   req_i.ready is low while any of that work runs.
// Reset empties the table, drops any pending string and sets table_size
// to 64. A stalled receiver holds the output register; the sequencer waits
// before loading the next result, and requests that give no result still
// pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_hash_string_table
  import dhst_pkg::*;
#(
  parameter int TABLE_DEPTH    = 64,
  parameter int MAX_STRING_LEN = 49
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dhst_cfg_if.sink  cfg_i,
  dhst_req_if.sink  req_i,
  dhst_rsp_if.source rsp_o
);

  localparam int SW    = $clog2(TABLE_DEPTH);
  localparam int NW    = SW + 1;
  localparam int LEN_W = $clog2(MAX_STRING_LEN + 1);
  localparam int PW    = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1;
  localparam int STD   = TABLE_DEPTH * MAX_STRING_LEN;
  localparam int STW   = $clog2(STD);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV1  = 4'd1;
  localparam logic [3:0] S_DIV2  = 4'd2;
  localparam logic [3:0] S_PROBE = 4'd3;
  localparam logic [3:0] S_COPY  = 4'd4;
  localparam logic [3:0] S_EMIT  = 4'd5;
  localparam logic [3:0] S_QLEN  = 4'd6;
  localparam logic [3:0] S_QRD   = 4'd7;
  localparam logic [3:0] S_QOUT  = 4'd8;

  logic [3:0]             state_q, state_d;
  logic [CFG_W-1:0]       ts_q;
  logic [NW-1:0]          n_eff;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [LEN_W-1:0]       cnt_q, cnt_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SUM_W-1:0]       dvd_q, dvd_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [LEN_W-1:0]       k_q, k_d;
  logic [SW-1:0]          h1_q, h1_d;
  logic [SW-1:0]          h2_q, h2_d;
  logic [SW-1:0]          j_q, j_d;
  logic [NW-1:0]          i_q, i_d;
  logic [STW-1:0]         base_q, base_d;
  logic                   copy_wr_q, copy_wr_d;
  logic [LEN_W-1:0]       copy_wk_q, copy_wk_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic                   nf_q, nf_d;
  logic [STATUS_W-1:0]    res_status_q, res_status_d;
  logic [KEY_W-1:0]       res_slot_q, res_slot_d;

  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;
  logic [KEY_W-1:0]       out_slot_q, out_slot_d;
  logic [CHAR_W-1:0]      out_char_q, out_char_d;
  logic                   out_final_q, out_final_d;
  logic                   can_load;

  logic                   accept;
  logic                   take_char;
  logic [SUM_W-1:0]       sum_add;
  logic [SW-1:0]          key_slot;
  logic [NW-1:0]          j_sum;

  logic                   mod_start;
  logic [NW-1:0]          mod_divisor;
  logic                   mod_done;
  logic [NW-1:0]          mod_rem;

  logic                   pend_we;
  logic                   pend_re;
  logic [CHAR_W-1:0]      pend_rdata;
  logic                   len_we;
  logic                   len_re;
  logic [SW-1:0]          len_raddr;
  logic [LEN_W-1:0]       len_rdata;
  logic                   store_re;
  logic [CHAR_W-1:0]      store_rdata;

  // clamp table_size into [2, TABLE_DEPTH]
  always_comb begin
    if (ts_q < CFG_W'(2)) begin
      n_eff = NW'(2);
    end else if (int'(ts_q) > TABLE_DEPTH) begin
      n_eff = NW'(TABLE_DEPTH);
    end else begin
      n_eff = NW'(ts_q);
    end
  end

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && (state_q == S_IDLE);
  assign can_load    = !out_valid_q || rsp_o.ready;
  assign take_char   = (int'(cnt_q) < MAX_STRING_LEN);
  assign sum_add     = take_char ? sum_q + SUM_W'(req_i.char_code) : sum_q;
  assign key_slot    = SW'(req_i.query_key);
  assign j_sum       = {1'b0, j_q} + {1'b0, h2_q};

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    cnt_d        = cnt_q;
    sum_d        = sum_q;
    dvd_d        = dvd_q;
    len_d        = len_q;
    k_d          = k_q;
    h1_d         = h1_q;
    h2_d         = h2_q;
    j_d          = j_q;
    i_d          = i_q;
    base_d       = base_q;
    copy_wr_d    = 1'b0;
    copy_wk_d    = copy_wk_q;
    key_d        = key_q;
    nf_d         = nf_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_char_d   = out_char_q;
    out_final_d  = out_final_q;
    mod_start    = 1'b0;
    mod_divisor  = n_eff;
    pend_we      = 1'b0;
    pend_re      = 1'b0;
    len_we       = 1'b0;
    len_re       = 1'b0;
    len_raddr    = key_slot;
    store_re     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.command)
            CMD_CLEAR: begin
              valid_d = '0;
            end
            CMD_INSERT: begin
              pend_we = take_char;
              cnt_d   = take_char ? cnt_q + LEN_W'(1) : cnt_q;
              sum_d   = sum_add;
              if (req_i.last_char) begin
                len_d     = cnt_d;
                dvd_d     = sum_add;
                mod_start = 1'b1;
                cnt_d     = '0;
                sum_d     = '0;
                state_d   = S_DIV1;
              end
            end
            CMD_QUERY: begin
              len_re  = 1'b1;
              key_d   = req_i.query_key;
              nf_d    = (int'(req_i.query_key) >= int'(n_eff)) || !valid_q[key_slot];
              base_d  = STW'(key_slot * MAX_STRING_LEN);
              state_d = S_QLEN;
            end
            default: begin
              // unused code: drop
            end
          endcase
        end
      end
      S_DIV1: begin
        if (mod_done) begin
          h1_d        = SW'(mod_rem);
          mod_divisor = n_eff - NW'(1);
          mod_start   = 1'b1;
          state_d     = S_DIV2;
        end
      end
      S_DIV2: begin
        mod_divisor = n_eff - NW'(1);
        if (mod_done) begin
          h2_d    = SW'(mod_rem) + SW'(1);
          j_d     = h1_q;
          i_d     = '0;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!valid_q[j_q]) begin
          valid_d[j_q] = 1'b1;
          len_we       = 1'b1;
          base_d       = STW'(j_q * MAX_STRING_LEN);
          res_status_d = STAT_INSERTED;
          res_slot_d   = KEY_W'(j_q);
          k_d          = '0;
          state_d      = S_COPY;
        end else if (i_q == n_eff - NW'(1)) begin
          res_status_d = STAT_FULL;
          res_slot_d   = '0;
          state_d      = S_EMIT;
        end else begin
          j_d = (j_sum >= n_eff) ? SW'(j_sum - n_eff) : SW'(j_sum);
          i_d = i_q + NW'(1);
        end
      end
      S_COPY: begin
        // read pending buffer one entry ahead of the store write
        if (k_q < len_q) begin
          pend_re   = 1'b1;
          copy_wr_d = 1'b1;
          copy_wk_d = k_q;
          k_d       = k_q + LEN_W'(1);
        end else if (!copy_wr_q) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_char_d   = '0;
          out_final_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_QLEN: begin
        if (nf_q || (len_rdata == '0)) begin
          res_status_d = STAT_NOT_FOUND;
          res_slot_d   = key_q;
          state_d      = S_EMIT;
        end else begin
          len_d   = len_rdata;
          k_d     = '0;
          state_d = S_QRD;
        end
      end
      S_QRD: begin
        store_re = 1'b1;
        state_d  = S_QOUT;
      end
      S_QOUT: begin
        if (can_load) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_FOUND;
          out_slot_d   = key_q;
          out_char_d   = store_rdata;
          out_final_d  = (k_q + LEN_W'(1) == len_q);
          if (k_q + LEN_W'(1) == len_q) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + LEN_W'(1);
            state_d = S_QRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ts_q        <= TABLE_SIZE_RESET;
      valid_q     <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      copy_wr_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      copy_wr_q   <= copy_wr_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        ts_q <= cfg_i.table_size;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q        <= dvd_d;
    len_q        <= len_d;
    k_q          <= k_d;
    h1_q         <= h1_d;
    h2_q         <= h2_d;
    j_q          <= j_d;
    i_q          <= i_d;
    base_q       <= base_d;
    copy_wk_q    <= copy_wk_d;
    key_q        <= key_d;
    nf_q         <= nf_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_char_q   <= out_char_d;
    out_final_q  <= out_final_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.slot         = out_slot_q;
  assign rsp_o.char_out     = out_char_q;
  assign rsp_o.final_result = out_final_q;

  dhst_mod_unit #(
    .DVD_W (SUM_W),
    .DSR_W (NW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (dvd_d),
    .divisor_i  (mod_divisor),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  dhst_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_STRING_LEN)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (cnt_q[PW-1:0]),
    .wdata_i (req_i.char_code),
    .re_i    (pend_re),
    .raddr_i (k_q[PW-1:0]),
    .rdata_o (pend_rdata)
  );

  dhst_ram #(
    .WIDTH (LEN_W),
    .DEPTH (TABLE_DEPTH)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (j_q),
    .wdata_i (len_q),
    .re_i    (len_re),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  dhst_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (STD)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (copy_wr_q),
    .waddr_i (base_q + STW'(copy_wk_q)),
    .wdata_i (pend_rdata),
    .re_i    (store_re),
    .raddr_i (base_q + STW'(k_q)),
    .rdata_o (store_rdata)
  );

endmodule

`default_nettype wire

@@ sv/dhst_ram.sv @@
// ----------------------------------------------------------------------------
// dhst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/dhst_mod_unit.sv @@
// ----------------------------------------------------------------------------
// dhst_mod_unit
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhst_mod_unit #(
  parameter int DVD_W = 13,
  parameter int DSR_W = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DSR_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DSR_W-1:0] rem_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DSR_W-1:0] dsr_q;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DSR_W:0]   trial;

  always_comb begin
    trial  = {rem_q, dvd_q[DVD_W-1]};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in next dividend bit, subtract divisor when it fits
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = DSR_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = DSR_W'(trial);
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ sv/dhst_checker.sv @@
// ----------------------------------------------------------------------------
// dhst_checker
// Port-level checks on the double hash string table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "double_hash_string_table_assert.svh"

module dhst_checker
  import dhst_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                req_valid_i,
  input wire logic                req_ready_i,
  input wire logic [CMD_W-1:0]    req_command_i,
  input wire logic                rsp_valid_i,
  input wire logic                rsp_ready_i,
  input wire logic [STATUS_W-1:0] rsp_status_i,
  input wire logic [KEY_W-1:0]    rsp_slot_i,
  input wire logic [CHAR_W-1:0]   rsp_char_out_i,
  input wire logic                rsp_final_i
);

  `DHST_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "result dropped while stalled")
  `DHST_ASSERT(a_rsp_stable, rsp_valid_i && !rsp_ready_i |=> $stable(rsp_status_i) && $stable(rsp_slot_i) && $stable(rsp_char_out_i) && $stable(rsp_final_i), "stalled result changed")
  `DHST_ASSERT(a_query_busy, req_valid_i && req_ready_i && (req_command_i == CMD_QUERY) |=> !req_ready_i, "query did not hold off requests")
  `DHST_ASSERT(a_full_fields, rsp_valid_i && (rsp_status_i == STAT_FULL) |-> (rsp_slot_i == '0) && (rsp_char_out_i == '0) && rsp_final_i, "full result fields wrong")
  `DHST_ASSERT(a_single_final, rsp_valid_i && ((rsp_status_i == STAT_INSERTED) || (rsp_status_i == STAT_NOT_FOUND)) |-> rsp_final_i && (rsp_char_out_i == '0), "single result not final")

endmodule

bind double_hash_string_table dhst_checker u_dhst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_command_i  (req_i.command),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_slot_i     (rsp_o.slot),
  .rsp_char_out_i (rsp_o.char_out),
  .rsp_final_i    (rsp_o.final_result)
);

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double hash string table. Requests go in over
// the request channel, and a local copy of the table predicts every result.
// Directed tests cover clears, full tables, long strings, range limits and
// table_size extremes. Random phases then vary sender idling and receiver
// stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dhst_pkg::*;

  localparam int DEPTH      = 64;
  localparam int MAX_LEN    = 49;
  localparam int SETTLE     = 250;
  localparam int CYCLE_CAP  = 1500000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    slot;
    logic [CHAR_W-1:0]   ch;
    logic                fin;
  } table_result_t;

  logic clk_i;
  logic rst_ni;

  dhst_cfg_if cfg_bus ();
  dhst_req_if req_bus ();
  dhst_rsp_if rsp_bus ();

  double_hash_string_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // table image
  int unsigned       size_reg;
  bit                slot_used [DEPTH];
  logic [CHAR_W-1:0] slot_chars [DEPTH][MAX_LEN];
  int unsigned       slot_len [DEPTH];
  logic [CHAR_W-1:0] open_chars [MAX_LEN];
  int unsigned       open_count;
  int unsigned       open_sum;

  table_result_t expected_results[$];

  int errors;
  int requests_sent;
  int results_seen;
  int inserts_done;
  int fulls_seen;
  int found_chars;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  bit hold_request;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left = 400;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    table_result_t exp_r;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $error("unexpected result: status %0d slot %0d char %0d final %0d",
               rsp_bus.status, rsp_bus.slot, rsp_bus.char_out, rsp_bus.final_result);
      end else begin
        exp_r = expected_results.pop_front();
        if (rsp_bus.status !== exp_r.status) begin
          errors++;
          $error("status: expected %0d, got %0d", exp_r.status, rsp_bus.status);
        end
        if (rsp_bus.slot !== exp_r.slot) begin
          errors++;
          $error("slot: expected %0d, got %0d", exp_r.slot, rsp_bus.slot);
        end
        if (rsp_bus.char_out !== exp_r.ch) begin
          errors++;
          $error("char_out: expected %0d, got %0d", exp_r.ch, rsp_bus.char_out);
        end
        if (rsp_bus.final_result !== exp_r.fin) begin
          errors++;
          $error("final_result: expected %0d, got %0d", exp_r.fin, rsp_bus.final_result);
        end
      end
    end
  end

  function automatic void push_result(logic [STATUS_W-1:0] st, int unsigned slot,
                                      logic [CHAR_W-1:0] ch, logic fin);
    table_result_t r;
    r.status = st;
    r.slot   = slot[KEY_W-1:0];
    r.ch     = ch;
    r.fin    = fin;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_table(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                        logic last, logic [KEY_W-1:0] key);
    int unsigned n;
    int unsigned step;
    int unsigned j;
    bit placed;
    n = (size_reg < 2) ? 2 : ((size_reg > DEPTH) ? DEPTH : size_reg);
    placed = 1'b0;
    case (cmd)
      CMD_CLEAR: begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
      end
      CMD_INSERT: begin
        if (open_count < MAX_LEN) begin
          open_chars[open_count] = ch;
          open_count++;
          open_sum = (open_sum + int'(ch)) & 32'h1fff;
        end
        if (last) begin
          j = open_sum % n;
          step = 1 + open_sum % (n - 1);
          for (int i = 0; i < n && !placed; i++) begin
            if (!slot_used[j]) begin
              slot_used[j] = 1'b1;
              slot_len[j] = open_count;
              for (int k = 0; k < open_count; k++) slot_chars[j][k] = open_chars[k];
              push_result(STAT_INSERTED, j, '0, 1'b1);
              inserts_done++;
              placed = 1'b1;
            end
            j = (j + step) % n;
          end
          if (!placed) begin
            push_result(STAT_FULL, 0, '0, 1'b1);
            fulls_seen++;
          end
          open_count = 0;
          open_sum = 0;
        end
      end
      CMD_QUERY: begin
        if (int'(key) >= n || !slot_used[key] || slot_len[key] == 0) begin
          push_result(STAT_NOT_FOUND, int'(key), '0, 1'b1);
        end else begin
          for (int k = 0; k < slot_len[key]; k++) begin
            push_result(STAT_FOUND, int'(key), slot_chars[key][k],
                        (k + 1 == slot_len[key]));
            found_chars++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                              logic last, logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.command   <= cmd;
    req_bus.char_code <= ch;
    req_bus.last_char <= last;
    req_bus.query_key <= key;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    predict_table(cmd, ch, last, key);
    if (cmd != CMD_UNUSED) requests_sent++;
  endtask

  task automatic stop_sending();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every result, then let any result-free work finish
  task automatic drain();
    stop_sending();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_table_size(logic [CFG_W-1:0] value);
    drain();
    cfg_bus.valid      <= 1'b1;
    cfg_bus.table_size <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    size_reg = int'(value);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic insert_string(int len, int code_lo, int code_hi);
    for (int k = 0; k < len; k++) begin
      send_request(CMD_INSERT, CHAR_W'($urandom_range(code_hi, code_lo)), (k == len - 1),
                   KEY_W'($urandom_range(63)));
    end
  endtask

  task automatic test_directed();
    // empty table, highest key, then strings at the code extremes
    send_request(CMD_QUERY, '0, 1'b0, 6'd0);
    send_request(CMD_QUERY, 7'h7f, 1'b1, 6'd63);
    send_request(CMD_INSERT, 7'd0, 1'b1, 6'd0);
    send_request(CMD_INSERT, 7'd127, 1'b0, 6'd63);
    send_request(CMD_INSERT, 7'd127, 1'b1, 6'd63);
    send_request(CMD_UNUSED, 7'd5, 1'b1, 6'd2);
    for (int s = 0; s < DEPTH; s++) begin
      if (slot_used[s]) send_request(CMD_QUERY, '0, 1'b0, KEY_W'(s));
    end
    // string past the length limit, the dropped last character ends it
    insert_string(52, 0, 127);
    for (int s = 0; s < DEPTH; s++) begin
      if (slot_used[s]) send_request(CMD_QUERY, '0, 1'b0, KEY_W'(s));
    end
    send_request(CMD_CLEAR, '0, 1'b0, '0);
    send_request(CMD_QUERY, '0, 1'b0, 6'd0);
  endtask

  task automatic test_small_table();
    write_table_size(7'd2);
    send_request(CMD_CLEAR, '0, 1'b0, '0);
    // third insert finds the two-slot table full
    for (int k = 0; k < 3; k++) insert_string(2, 1, 127);
    send_request(CMD_QUERY, '0, 1'b0, 6'd0);
    send_request(CMD_QUERY, '0, 1'b0, 6'd1);
    send_request(CMD_QUERY, '0, 1'b0, 6'd2);
    // pending string survives a clear
    send_request(CMD_INSERT, 7'd9, 1'b0, '0);
    send_request(CMD_CLEAR, '0, 1'b0, '0);
    send_request(CMD_INSERT, 7'd4, 1'b1, '0);
    write_table_size(7'd0);
    insert_string(1, 1, 127);
    insert_string(1, 1, 127);
    insert_string(1, 1, 127);
    write_table_size(7'd1);
    send_request(CMD_QUERY, '0, 1'b0, 6'd1);
    write_table_size(7'd127);
    send_request(CMD_QUERY, '0, 1'b0, 6'd1);
    send_request(CMD_QUERY, '0, 1'b0, 6'd63);
    write_table_size(7'd65);
  endtask

  task automatic test_backpressure();
    drain();
    hold_request = 1'b1;
    for (int k = 0; k < 4; k++) begin
      insert_string(3, 0, 127);
      send_request(CMD_QUERY, '0, 1'b0, KEY_W'($urandom_range(63)));
    end
    drain();
  endtask

  task automatic test_random(int count, logic [CFG_W-1:0] size_val);
    int sent;
    int pick;
    int key;
    write_table_size(size_val);
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        key = ($urandom_range(19) == 0) ? $urandom_range(55, 50) : $urandom_range(6, 1);
        insert_string(key, 0, 127);
        sent += key;
      end else if (pick < 88) begin
        key = $urandom_range(63);
        for (int t = 0; t < 8; t++) begin
          if ($urandom_range(2) != 0 && !slot_used[key]) key = $urandom_range(63);
        end
        send_request(CMD_QUERY, CHAR_W'($urandom_range(127)), 1'($urandom_range(1)),
                     KEY_W'(key));
        sent++;
      end else if (pick < 93) begin
        send_request(CMD_CLEAR, CHAR_W'($urandom_range(127)), 1'($urandom_range(1)),
                     KEY_W'($urandom_range(63)));
        sent++;
      end else begin
        send_request(CMD_UNUSED, CHAR_W'($urandom_range(127)), 1'($urandom_range(1)),
                     KEY_W'($urandom_range(63)));
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.table_size = '0;
    req_bus.valid      = 1'b0;
    req_bus.command    = CMD_CLEAR;
    req_bus.char_code  = '0;
    req_bus.last_char  = 1'b0;
    req_bus.query_key  = '0;
    rsp_bus.ready      = 1'b0;
    size_reg       = int'(TABLE_SIZE_RESET);
    open_count     = 0;
    open_sum       = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    foreach (slot_len[i]) slot_len[i] = 0;
    errors         = 0;
    requests_sent  = 0;
    results_seen   = 0;
    inserts_done   = 0;
    fulls_seen     = 0;
    found_chars    = 0;
    cycles         = 0;
    hold_left      = 0;
    hold_request   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_small_table();
    test_backpressure();
    send_idle_pct  = 32;
    recv_stall_pct = 74;
    test_random(100, 7'd64);
    send_idle_pct  = 74;
    recv_stall_pct = 32;
    test_random(100, 7'd7);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random(100, 7'd29);
    drain();

    $display("covered %0d requests, %0d results: %0d inserts, %0d full, %0d found chars",
             requests_sent, results_seen, inserts_done, fulls_seen, found_chars);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
